// ----- src/fixed_point_alu_defines.svh -----
// Assertion macros for the fixed-point ALU.
// Included by fixed_point_alu.sv, the RTL file with concurrent assertions; no dependencies.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a condition that must hold in the same cycle as its trigger
`define FPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("fixed_point_alu: check failed");

// Check a condition that must hold in the cycle after its trigger
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("fixed_point_alu: check failed");

`else

`define FPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/fpa_pkg.sv -----
// Shared constants, operation codes and pipeline types of the fixed-point ALU.
// No dependencies; used by every module of the block.
`default_nettype none

package fpa_pkg;

    // Number format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 8;

    // Quotient magnitude width: |a| needs DATA_W bits, shifted left by FRAC_BITS
    localparam int QUOT_W    = DATA_W + FRAC_BITS;

    // Cycles from an accepted beat to its result strobe
    localparam int LATENCY   = QUOT_W + 3;

    // Operation codes
    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_GT      = 4'd4;
    localparam logic [3:0] OP_LT      = 4'd5;
    localparam logic [3:0] OP_GE      = 4'd6;
    localparam logic [3:0] OP_LE      = 4'd7;
    localparam logic [3:0] OP_EQ      = 4'd8;
    localparam logic [3:0] OP_NE      = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_MAX     = 4'd11;
    localparam logic [3:0] OP_INC     = 4'd12;
    localparam logic [3:0] OP_DEC     = 4'd13;
    localparam logic [3:0] OP_INT2FIX = 4'd14;
    localparam logic [3:0] OP_FIX2INT = 4'd15;

    // Payload of one beat inside the divider pipeline
    typedef struct packed {
        logic              is_div;  // result comes from the quotient
        logic              neg;     // quotient sign is negative
        logic              dz;      // divisor was zero
        logic              cmp;     // comparison outcome
        logic [DATA_W-1:0] value;   // result of every non-divide operation
        logic [DATA_W-1:0] rem;     // partial remainder
        logic [QUOT_W-1:0] nq;      // dividend bits on top, quotient bits below
        logic [DATA_W-1:0] den;     // divisor magnitude
    } fpa_stage_t;

endpackage

`default_nettype wire

// ----- src/fpa_front.sv -----
// Front end of the fixed-point ALU: operand decode, simple operations, multiplier.
// Two register stages; uses fpa_pkg for codes and the stage type.
`default_nettype none

module fpa_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [3:0]                        action,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output logic                                   out_valid,
    output fpa_pkg::fpa_stage_t                    out_stage
);

    typedef struct packed {
        logic                          is_mul;
        logic                          is_div;
        logic                          neg;
        logic                          dz;
        logic                          cmp;
        logic [fpa_pkg::DATA_W-1:0]    value;
        logic [2*fpa_pkg::DATA_W-1:0]  prod;
        logic [fpa_pkg::DATA_W-1:0]    mag_a;
        logic [fpa_pkg::DATA_W-1:0]    mag_b;
    } fpa_pre_t;

    logic                                  pre_valid_reg;
    fpa_pre_t                              pre_reg;
    fpa_pre_t                              pre_next;
    logic signed [2*fpa_pkg::DATA_W-1:0]   product;
    logic                                  stage_valid_reg;
    fpa_pkg::fpa_stage_t                   stage_reg;
    fpa_pkg::fpa_stage_t                   stage_next;

    // Full signed product; the scaling shift waits for the next stage
    assign product = (2*fpa_pkg::DATA_W)'(operand_a) * (2*fpa_pkg::DATA_W)'(operand_b);

    // Decode the operation and work out everything but the quotient
    always_comb
    begin
        pre_next        = '0;
        pre_next.prod   = product;
        pre_next.mag_a  = operand_a[fpa_pkg::DATA_W-1] ? $unsigned(-operand_a)
                                                       : $unsigned(operand_a);
        pre_next.mag_b  = operand_b[fpa_pkg::DATA_W-1] ? $unsigned(-operand_b)
                                                       : $unsigned(operand_b);
        pre_next.neg    = operand_a[fpa_pkg::DATA_W-1] ^ operand_b[fpa_pkg::DATA_W-1];
        case (action)
            fpa_pkg::OP_ADD:     pre_next.value = $unsigned(operand_a + operand_b);
            fpa_pkg::OP_SUB:     pre_next.value = $unsigned(operand_a - operand_b);
            fpa_pkg::OP_MUL:     pre_next.is_mul = 1'b1;
            fpa_pkg::OP_DIV:
            begin
                pre_next.is_div = 1'b1;
                pre_next.dz     = (operand_b == '0);
            end
            fpa_pkg::OP_GT:      pre_next.cmp = (operand_a > operand_b);
            fpa_pkg::OP_LT:      pre_next.cmp = (operand_a < operand_b);
            fpa_pkg::OP_GE:      pre_next.cmp = (operand_a >= operand_b);
            fpa_pkg::OP_LE:      pre_next.cmp = (operand_a <= operand_b);
            fpa_pkg::OP_EQ:      pre_next.cmp = (operand_a == operand_b);
            fpa_pkg::OP_NE:      pre_next.cmp = (operand_a != operand_b);
            fpa_pkg::OP_MIN:     pre_next.value = (operand_a < operand_b) ? operand_a : operand_b;
            fpa_pkg::OP_MAX:     pre_next.value = (operand_a > operand_b) ? operand_a : operand_b;
            fpa_pkg::OP_INC:     pre_next.value = $unsigned(operand_a)
                                                  + {{(fpa_pkg::DATA_W-1){1'b0}}, 1'b1};
            fpa_pkg::OP_DEC:     pre_next.value = $unsigned(operand_a)
                                                  - {{(fpa_pkg::DATA_W-1){1'b0}}, 1'b1};
            fpa_pkg::OP_INT2FIX: pre_next.value = $unsigned(operand_a) << fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_FIX2INT: pre_next.value = $unsigned(operand_a >>> fpa_pkg::FRAC_BITS);
            default:             pre_next.value = '0;
        endcase
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            pre_valid_reg   <= in_valid;
            stage_valid_reg <= pre_valid_reg;
        end
    end

    // Scale the product and load the divider operands
    always_comb
    begin
        stage_next        = '0;
        stage_next.is_div = pre_reg.is_div;
        stage_next.neg    = pre_reg.neg;
        stage_next.dz     = pre_reg.dz;
        stage_next.cmp    = pre_reg.cmp;
        stage_next.value  = pre_reg.is_mul
            ? pre_reg.prod[fpa_pkg::FRAC_BITS+fpa_pkg::DATA_W-1:fpa_pkg::FRAC_BITS]
            : pre_reg.value;
        stage_next.nq     = {pre_reg.mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
        stage_next.den    = pre_reg.mag_b;
    end

    // Hold the payload of both stages
    always_ff @(posedge clk)
    begin
        pre_reg   <= pre_next;
        stage_reg <= stage_next;
    end

    assign out_valid = stage_valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// ----- src/fpa_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Carries the rest of each beat alongside; uses fpa_pkg for widths and the stage type.
`default_nettype none

module fpa_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire fpa_pkg::fpa_stage_t in_stage,
    output logic                     out_valid,
    output fpa_pkg::fpa_stage_t      out_stage
);

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic fpa_pkg::fpa_stage_t div_step(input fpa_pkg::fpa_stage_t s);
        fpa_pkg::fpa_stage_t          r;
        logic [fpa_pkg::DATA_W:0]     shifted;
        logic [fpa_pkg::DATA_W+1:0]   diff;
        logic                         ge;
        r       = s;
        shifted = {s.rem, s.nq[fpa_pkg::QUOT_W-1]};
        diff    = {1'b0, shifted} - {2'b00, s.den};
        ge      = ~diff[fpa_pkg::DATA_W+1];
        r.rem   = ge ? diff[fpa_pkg::DATA_W-1:0] : shifted[fpa_pkg::DATA_W-1:0];
        r.nq    = {s.nq[fpa_pkg::QUOT_W-2:0], ge};
        return r;
    endfunction

    logic [fpa_pkg::QUOT_W-1:0] valid_reg;
    fpa_pkg::fpa_stage_t        stage_reg  [fpa_pkg::QUOT_W];
    fpa_pkg::fpa_stage_t        stage_next [fpa_pkg::QUOT_W];

    for (genvar i = 0; i < fpa_pkg::QUOT_W; i++)
    begin : g_stage
        logic                prev_valid;
        fpa_pkg::fpa_stage_t prev_stage;

        // Pick up the beat from the previous stage
        if (i == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign prev_stage = in_stage;
        end
        else
        begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_stage = stage_reg[i-1];
        end

        always_comb
        begin
            stage_next[i] = div_step(prev_stage);
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= prev_valid;
            end
        end

        // Hold the payload
        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next[i];
        end
    end

    assign out_valid = valid_reg[fpa_pkg::QUOT_W-1];
    assign out_stage = stage_reg[fpa_pkg::QUOT_W-1];

endmodule

`default_nettype wire

// ----- src/fpa_back.sv -----
// Result stage of the fixed-point ALU: quotient sign fix and output registers.
// Uses fpa_pkg for widths and the stage type.
`default_nettype none

module fpa_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire fpa_pkg::fpa_stage_t          in_stage,
    output logic                              done,
    output logic signed [fpa_pkg::DATA_W-1:0] result_value,
    output logic                              compare_true,
    output logic                              divide_by_zero
);

    logic                       done_reg;
    logic [fpa_pkg::DATA_W-1:0] value_reg;
    logic [fpa_pkg::DATA_W-1:0] value_next;
    logic                       cmp_reg;
    logic                       dz_reg;
    logic [fpa_pkg::DATA_W-1:0] quot;

    // Keep the low word of the quotient magnitude
    assign quot = in_stage.nq[fpa_pkg::DATA_W-1:0];

    // Pass non-divide values through; apply the quotient sign, zero on a zero divisor
    always_comb
    begin
        if (!in_stage.is_div)
        begin
            value_next = in_stage.value;
        end
        else if (in_stage.dz)
        begin
            value_next = '0;
        end
        else
        begin
            value_next = in_stage.neg ? -quot : quot;
        end
    end

    // Strobe one result beat per valid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cmp_reg   <= in_stage.cmp;
        dz_reg    <= in_stage.is_div & in_stage.dz;
    end

    assign done           = done_reg;
    assign result_value   = $signed(value_reg);
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire

// ----- src/fixed_point_alu.sv -----
// Fixed-point ALU, signed 32-bit raw words with FRAC_BITS fraction bits.
// Every operation takes the same path from start to the done strobe: the front-end registers,
// the divider, which retires one quotient bit per stage, and the result registers.
// Throughput: one beat per cycle; busy stays low and done cannot be held off.
// Reset clears all valid bits at once; no done strobe follows until a new beat is started.
`default_nettype none
`include "fixed_point_alu_defines.svh"

module fixed_point_alu (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [3:0]                        action,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output logic                                   done,
    output logic signed [fpa_pkg::DATA_W-1:0]      result_value,
    output logic                                   compare_true,
    output logic                                   divide_by_zero
);

    logic                front_valid;
    fpa_pkg::fpa_stage_t front_stage;
    logic                div_valid;
    fpa_pkg::fpa_stage_t div_stage;

    // The pipeline never stalls, so a new beat is taken every cycle
    assign busy = 1'b0;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (front_valid),
        .out_stage (front_stage)
    );

    fpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stage  (front_stage),
        .out_valid (div_valid),
        .out_stage (div_stage)
    );

    fpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid),
        .in_stage       (div_stage),
        .done           (done),
        .result_value   (result_value),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

    // Every started beat comes out after the fixed latency
    `FPA_ASSERT_NOW(a_start_to_done, clk, rst_n, start && !busy, ##(fpa_pkg::LATENCY) done)
    // A zero divisor yields a zero value
    `FPA_ASSERT_NOW(a_dz_value, clk, rst_n, done && divide_by_zero, result_value == '0)
    // A true comparison carries a zero value
    `FPA_ASSERT_NOW(a_cmp_value, clk, rst_n, done && compare_true, result_value == '0)
    // Comparison and divide flags never come together
    `FPA_ASSERT_NOW(a_flags_apart, clk, rst_n, done, !(compare_true && divide_by_zero))

endmodule

`default_nettype wire

// ----- tb/tb_fixed_point_alu.sv -----
// Self-checking testbench for the fixed-point ALU: directed table, then random beats.
// Depends on fpa_pkg and fixed_point_alu; results are checked against an in-file predictor.
`default_nettype none

module tb_fixed_point_alu;

    import fpa_pkg::*;

    localparam int N_RANDOM   = 1150;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              cmp;
        logic              dz;
    } alu_result_t;

    typedef struct {
        logic [3:0]        act;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        bit                known;
        alu_result_t       res;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [3:0]               action;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic                     done;
    logic signed [DATA_W-1:0] result_value;
    logic                     compare_true;
    logic                     divide_by_zero;

    alu_result_t pending_results[$];
    dir_row_t    dir_rows[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;

    fixed_point_alu i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .done           (done),
        .result_value   (result_value),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop if the block hangs
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Compute the expected result of one beat
    function automatic alu_result_t alu_compute(input logic [3:0] act,
                                                input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [63:0] wide;
        alu_result_t        r;
        sa = {{32{a[DATA_W-1]}}, a};
        sb = {{32{b[DATA_W-1]}}, b};
        r  = '0;
        case (act)
            OP_ADD:     r.value = a + b;
            OP_SUB:     r.value = a - b;
            OP_MUL:
            begin
                wide    = (sa * sb) >>> FRAC_BITS;
                r.value = wide[DATA_W-1:0];
            end
            OP_DIV:
            begin
                if (b == '0)
                    r.dz = 1'b1;
                else
                begin
                    // Widen the dividend, then truncate toward zero
                    wide    = (sa <<< FRAC_BITS) / sb;
                    r.value = wide[DATA_W-1:0];
                end
            end
            OP_GT:      r.cmp = (sa >  sb);
            OP_LT:      r.cmp = (sa <  sb);
            OP_GE:      r.cmp = (sa >= sb);
            OP_LE:      r.cmp = (sa <= sb);
            OP_EQ:      r.cmp = (sa == sb);
            OP_NE:      r.cmp = (sa != sb);
            OP_MIN:     r.value = (sa < sb) ? a : b;
            OP_MAX:     r.value = (sa > sb) ? a : b;
            OP_INC:     r.value = a + 1;
            OP_DEC:     r.value = a - 1;
            OP_INT2FIX: r.value = a << FRAC_BITS;
            default:
            begin
                // Fixed to integer rounds toward minus infinity
                wide    = sa >>> FRAC_BITS;
                r.value = wide[DATA_W-1:0];
            end
        endcase
        return r;
    endfunction

    // Pick an operand: half full range, the rest small values and extremes
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5:             v = $urandom_range(0, 1023) - 512;
            6:             v = ($urandom_range(0, 255) - 128) << FRAC_BITS;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    4:       v = 32'hFFFF_FFFF;
                    default: v = 32'hFFFF_FF00;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_row(input logic [3:0] act, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input bit known,
                           input logic [DATA_W-1:0] value, input logic cmp, input logic dz);
        dir_row_t row;
        row.act       = act;
        row.a         = a;
        row.b         = b;
        row.known     = known;
        row.res.value = value;
        row.res.cmp   = cmp;
        row.res.dz    = dz;
        dir_rows.push_back(row);
    endtask

    // Insert a random gap, at times none, at the start of each burst
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one beat, hold it until accepted, then record its expected result
    task automatic issue_beat(input logic [3:0] act, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b, input alu_result_t res);
        action    <= act;
        operand_a <= a;
        operand_b <= b;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(res);
    endtask

    // Check each result strobe against the oldest expectation
    always @(negedge clk)
    begin
        alu_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("unexpected result: value=%h cmp=%b dz=%b",
                             result_value, compare_true, divide_by_zero);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value || compare_true !== want.cmp ||
                    divide_by_zero !== want.dz)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("mismatch: val exp=%h got=%h cmp exp=%b got=%b dz exp=%b got=%b",
                                 want.value, result_value, want.cmp, compare_true,
                                 want.dz, divide_by_zero);
                end
            end
        end
    end

    // Stimulus: reset, directed table, random beats, drain
    initial
    begin
        logic [3:0]        act;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int                drain;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        action    <= OP_ADD;
        operand_a <= '0;
        operand_b <= '0;

        // Expected value typed in only where it is obvious
        add_row(OP_ADD,     32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
        add_row(OP_ADD,     32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
        add_row(OP_SUB,     32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_row(OP_MUL,     32'h0000_0100, 32'h0000_0180, 1'b1, 32'h0000_0180, 1'b0, 1'b0);
        add_row(OP_MUL,     32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_MUL,     32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_DIV,     32'h0000_0300, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
        add_row(OP_DIV,     32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
        add_row(OP_DIV,     32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_DIV,     32'h0000_0100, 32'h0000_0300, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_DIV,     32'hFFFF_FF00, 32'h0000_0300, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_GT,      32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
        add_row(OP_LT,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
        add_row(OP_GE,      32'h0000_0005, 32'h0000_0005, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
        add_row(OP_LE,      32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
        add_row(OP_EQ,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
        add_row(OP_NE,      32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
        add_row(OP_MIN,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
        add_row(OP_MAX,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_row(OP_MIN,     32'hFFFF_FFFD, 32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFD, 1'b0, 1'b0);
        add_row(OP_INC,     32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
        add_row(OP_DEC,     32'h8000_0000, 32'h1234_5678, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_row(OP_INT2FIX, 32'h0000_0001, 32'hDEAD_BEEF, 1'b1, 32'h0000_0100, 1'b0, 1'b0);
        add_row(OP_INT2FIX, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
        add_row(OP_FIX2INT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_row(OP_FIX2INT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h007F_FFFF, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            pace_sender();
            issue_beat(dir_rows[i].act, dir_rows[i].a, dir_rows[i].b,
                       dir_rows[i].known ? dir_rows[i].res
                                         : alu_compute(dir_rows[i].act, dir_rows[i].a,
                                                       dir_rows[i].b));
        end

        // Random beats, biased toward equal operands and zero divisors
        for (int n = 0; n < N_RANDOM; n++)
        begin
            act = 4'($urandom_range(0, 15));
            a   = pick_operand();
            b   = pick_operand();
            if (act >= OP_GT && act <= OP_MAX && $urandom_range(0, 5) == 0)
                b = a;
            if (act == OP_DIV && $urandom_range(0, 7) == 0)
                b = '0;
            pace_sender();
            issue_beat(act, a, b, alu_compute(act, a, b));
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes
        drain = 0;
        while (pending_results.size() != 0 && drain < 4 * LATENCY)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
